// ===== rtl/core/mxdq_pkg.sv =====
// Shared types, constants and the E2M1 x E8M0 to fp32 conversion function
// for the MXFP4 block dequantizer. No dependencies.
package mxdq_pkg;

    localparam int unsigned BlockElements = 32;
    localparam int unsigned PosWidth      = $clog2(BlockElements);
    localparam int unsigned QueueDepth    = 2;

    localparam logic [31:0] Fp32Inf  = 32'h7F80_0000;
    localparam logic [31:0] Fp32QNaN = 32'h7FC0_0000;
    localparam logic [31:0] Fp32Sign = 32'h8000_0000;

    // One queued block: scale byte and both code words
    typedef struct packed {
        logic [7:0]  scale_exp;
        logic [63:0] codes_high;
        logic [63:0] codes_low;
    } t_block;

    // Convert one 4-bit code with the shared scale byte into fp32 bits
    function automatic logic [31:0] dequant_one(input logic [7:0] sc, input logic [3:0] code);
        logic [31:0] sign;
        logic [3:0]  m;
        logic [1:0]  ulog;
        logic [22:0] frac;
        logic [9:0]  biased;
        logic [4:0]  sh;
        logic [31:0] res;
        sign   = code[3] ? Fp32Sign : 32'h0;
        unique case (code[2:0])
            3'd0: m = 4'd0;
            3'd1: m = 4'd1;
            3'd2: m = 4'd2;
            3'd3: m = 4'd3;
            3'd4: m = 4'd4;
            3'd5: m = 4'd6;
            3'd6: m = 4'd8;
            default: m = 4'd12;
        endcase
        ulog   = code[2:1];
        frac   = (code[0] && code[2:1] != 2'd0) ? 23'h40_0000 : 23'h0;
        // biased exponent plus one = ulog + sc (scale byte zero is 2^-127 as well)
        biased = 10'(ulog) + 10'(sc);
        // subnormal shift = sc + 21, only reached for sc of 0 or 1
        sh     = 5'(sc + 8'd21);
        if (sc == 8'hFF) begin
            res = (m == 4'd0) ? Fp32QNaN : (sign | Fp32Inf);
        end else if (m == 4'd0) begin
            res = sign;
        end else if (biased >= 10'd256) begin
            res = sign | Fp32Inf;
        end else if (biased >= 10'd2) begin
            res = sign | {1'b0, 8'(biased - 10'd1), frac};
        end else begin
            res = sign | (32'(m) << sh);
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/mxdq_front.sv =====
// Front end: accepts blocks and pushes them into a two-entry queue.
// Depends on mxdq_pkg.
module mxdq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  mxdq_pkg::t_block  i_block,
    input  logic              i_pop,
    output logic              o_nempty,
    output mxdq_pkg::t_block  o_block
);
    mxdq_pkg::t_block r_mem [mxdq_pkg::QueueDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready  = (r_cnt != 2'(mxdq_pkg::QueueDepth));
    assign o_nempty = (r_cnt != 2'd0);
    assign push     = i_valid && o_ready;
    assign pop      = i_pop && o_nempty;
    assign o_block  = r_mem[r_rp];

    // Store entry
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_block;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(mxdq_pkg::QueueDepth)) else $error("queue count overflow");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !pop) |=> r_cnt == 2'd2) else $error("full queue lost entry");
    a_ptr_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> r_wp == r_rp) else $error("pointer mismatch");
`endif
endmodule

// ===== rtl/core/mxdq_back.sv =====
// Back end: walks the 32 elements of the head block, converts and holds
// each result in an output register. Depends on mxdq_pkg.
module mxdq_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_nempty,
    input  mxdq_pkg::t_block  i_block,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [31:0]       o_value,
    output logic [4:0]        o_pos,
    output logic              o_last
);
    logic [mxdq_pkg::PosWidth-1:0] r_idx;
    logic        r_valid;
    logic [31:0] r_value;
    logic [4:0]  r_pos;
    logic        load;
    logic [3:0]  byte_idx;
    logic [7:0]  sel_byte;
    logic [127:0] codes;
    logic [3:0]  code;

    // Free output register when empty or being taken
    assign load     = i_nempty && (!r_valid || i_ready);
    assign o_pop    = load && (r_idx == 5'(mxdq_pkg::BlockElements - 1));
    assign byte_idx = r_idx[3:0];
    assign codes    = {i_block.codes_high, i_block.codes_low};
    assign sel_byte = codes[{byte_idx, 3'b000} +: 8];
    assign code     = r_idx[4] ? sel_byte[7:4] : sel_byte[3:0];

    // Hold result register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_value <= mxdq_pkg::dequant_one(i_block.scale_exp, code);
            r_pos   <= r_idx;
        end
    end

    // Advance element index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= r_idx + 5'd1;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_pos   = r_pos;
    assign o_last  = (r_pos == 5'(mxdq_pkg::BlockElements - 1));

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> $stable(r_pos)) else $error("result changed in stall");
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_pos == 5'd31)) else $error("pop without last element");
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_pos == $past(r_idx)) else $error("position out of order");
`endif
endmodule

// ===== rtl/core/mxfp4_block_dequantize.sv =====
// Top level of the MXFP4 block dequantizer: block queue front end and
// element conversion back end. Depends on mxdq_pkg, mxdq_front, mxdq_back.
//
// Input channel (s_axis): one beat carries a whole MX block, a scale byte and
// 16 bytes of packed E2M1 codes. Output channel (m_axis): one beat per fp32
// element, 32 beats per block, low nibbles first, tlast on position 31.
// The block beat is first written into the queue, and the first element is then
// converted into the output register. The single conversion unit emits one element
// per cycle from the head of the queue while it holds a block and the receiver is ready.
// A two-block queue lets the next block be accepted while the current one
// is still being emitted. When the receiver holds tready low, the output
// register holds its beat and the element walk pauses; the queue fills and
// then s_axis_tready drops. Reset (synchronous, active low) empties the
// queue, clears the element index and drops m_axis_tvalid.
module mxfp4_block_dequantize (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [135:0]  s_axis_tdata,   // scale_exp[7:0], codes_low[71:8], codes_high[135:72]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [39:0]   m_axis_tdata,   // value_bits[31:0], position[36:32], zero pad
    output logic          m_axis_tlast    // last
);
    mxdq_pkg::t_block in_blk, head_blk;
    logic nempty, pop;
    logic [31:0] value;
    logic [4:0]  pos;

    assign in_blk.scale_exp  = s_axis_tdata[7:0];
    assign in_blk.codes_low  = s_axis_tdata[71:8];
    assign in_blk.codes_high = s_axis_tdata[135:72];

    mxdq_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_block(in_blk),
        .i_pop(pop), .o_nempty(nempty), .o_block(head_blk)
    );

    mxdq_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_nempty(nempty), .i_block(head_blk), .o_pop(pop),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_value(value), .o_pos(pos), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, pos, value};
endmodule

// ===== tb/tb.sv =====
// Testbench for mxfp4_block_dequantize: drives MX blocks on the input stream
// and checks every fp32 element beat against an in-bench predictor. Needs the RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] value_bits;
        logic [4:0]  position;
        logic        last;
    } t_elem;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [39:0]  m_axis_tdata;
    logic         m_axis_tlast;

    logic [135:0] block_q[$];
    t_elem        elem_q[$];
    int           errors = 0;
    int           idle_cycles = 0;
    int           hold_count = 0;
    int           rx_hold = 0;
    int           tx_gap = 0;
    bit           stim_done = 1'b0;
    bit           drain_wait = 1'b0;
    bit           rx_long_done = 1'b0;
    bit           tx_accepted = 1'b0;

    mxfp4_block_dequantize u_top (.*);

    always #5 i_clk = ~i_clk;

    // Convert one E2M1 code with an E8M0 scale byte into fp32 bits
    function automatic logic [31:0] fp32_of_code(logic [7:0] sc, logic [3:0] code);
        logic [31:0] sgn;
        logic [3:0]  halves;
        int          lg;
        int          ex;
        int          bexp;
        logic [22:0] frac;
        sgn = code[3] ? 32'h8000_0000 : 32'h0;
        case (code[2:0])
            3'd0: halves = 0;  3'd1: halves = 1;  3'd2: halves = 2;  3'd3: halves = 3;
            3'd4: halves = 4;  3'd5: halves = 6;  3'd6: halves = 8;  default: halves = 12;
        endcase
        lg = code[2:1];
        frac = (code[0] && code[2:1] != 0) ? 23'h40_0000 : 23'h0;
        if (sc == 8'hFF) return (halves == 0) ? 32'h7FC0_0000 : (sgn | 32'h7F80_0000);
        if (halves == 0) return sgn;
        ex = (sc == 0) ? -127 : int'(sc) - 127;
        bexp = lg + ex + 126;
        if (bexp >= 255) return sgn | 32'h7F80_0000;
        if (bexp >= 1) return sgn | (32'(bexp) << 23) | 32'(frac);
        return sgn | (32'(halves) << (ex + 148));
    endfunction

    // Expand one accepted block into its 32 expected elements
    task automatic predict_block(logic [135:0] blk);
        logic [127:0] codes;
        logic [7:0]   byte_v;
        logic [3:0]   code;
        t_elem        e;
        codes = blk[135:8];
        for (int p = 0; p < 32; p++) begin
            byte_v = codes[(p % 16) * 8 +: 8];
            code = (p < 16) ? byte_v[3:0] : byte_v[7:4];
            e.value_bits = fp32_of_code(blk[7:0], code);
            e.position = 5'(p);
            e.last = (p == 31);
            elem_q.push_back(e);
        end
    endtask

    function automatic logic [135:0] rand_block(logic [7:0] sc);
        return {$urandom, $urandom, $urandom, $urandom, sc};
    endfunction

    function automatic int rand_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    endfunction

    // Fill the stimulus queue: directed blocks then random ones
    initial begin
        logic [7:0] sc;
        logic [135:0] all_codes;
        for (int i = 0; i < 16; i++) all_codes[8 + i*8 +: 8] = 8'((i << 4) | ((i + 3) & 15));
        for (int s = 0; s < 9; s++) begin
            case (s)
                0: sc = 8'd0;   1: sc = 8'd1;   2: sc = 8'd2;   3: sc = 8'd127;
                4: sc = 8'd128; 5: sc = 8'd252; 6: sc = 8'd253; 7: sc = 8'd254;
                default: sc = 8'd255;
            endcase
            block_q.push_back({all_codes[135:8], sc});
        end
        block_q.push_back({128'h0, 8'd100});
        block_q.push_back({{16{8'h88}}, 8'd255});
        block_q.push_back({{16{8'hFF}}, 8'd254});
        block_q.push_back({{16{8'h77}}, 8'd0});
        block_q.push_back({{16{8'h99}}, 8'd20});
        for (int n = 0; n < 266; n++) begin
            case ($urandom_range(0, 5))
                0: sc = 8'($urandom_range(0, 3));
                1: sc = 8'($urandom_range(250, 255));
                default: sc = 8'($urandom);
            endcase
            block_q.push_back(rand_block(sc));
        end
    end

    // Hold reset, then release it at a falling edge
    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Sample the input handshake at the rising edge
    always @(posedge i_clk) begin
        tx_accepted = i_rst_n && s_axis_tvalid && s_axis_tready;
    end

    // Drive input beats at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (tx_accepted) begin
                predict_block(s_axis_tdata);
                void'(block_q.pop_front());
                tx_gap = rand_gap();
                if (block_q.size() == 200) drain_wait = 1'b1;
            end
            if (drain_wait && elem_q.size() == 0) drain_wait = 1'b0;
            if (tx_gap > 0) tx_gap--;
            if (block_q.size() > 0 && tx_gap == 0 && !drain_wait) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= block_q[0];
            end else begin
                s_axis_tvalid <= 1'b0;
                if (block_q.size() == 0) stim_done = 1'b1;
            end
        end
    end

    // Receiver backpressure: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (!rx_long_done && block_q.size() == 240) begin
            rx_long_done = 1'b1;
            hold_count = 300;
        end
        if (hold_count > 0) begin
            hold_count--;
            m_axis_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 5) == 0) rx_hold = rand_gap();
        end
    end

    // Check output beats and watch for a hang
    always @(posedge i_clk) begin
        t_elem e;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 2000) begin
                $display("Mismatches found");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (elem_q.size() == 0) begin
                    $error("unexpected beat value_bits=%h", m_axis_tdata[31:0]);
                    errors++;
                end else begin
                    e = elem_q.pop_front();
                    if (m_axis_tdata[31:0] !== e.value_bits) begin
                        $error("value_bits exp %h got %h", e.value_bits, m_axis_tdata[31:0]);
                        errors++;
                    end
                    if (m_axis_tdata[36:32] !== e.position) begin
                        $error("position exp %0d got %0d", e.position, m_axis_tdata[36:32]);
                        errors++;
                    end
                    if (m_axis_tlast !== e.last) begin
                        $error("last exp %0b got %0b", e.last, m_axis_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    // Finish once every block is sent and every element has come back
    initial begin
        wait (stim_done && elem_q.size() == 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && elem_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
